@@ sv/vrsp_pkg.sv @@
package vrsp_pkg;

    localparam int COORD_WIDTH_DEF    = 16;
    localparam int TRIG_FRAC_BITS_DEF = 14;
    localparam int CORDIC_ITERS       = 16;
    localparam int ANGLE_W            = 13;
    localparam int SCALE_W            = 12;
    localparam int SHIFT_W            = 16;
    localparam int ADDR_W             = 5;
    localparam int FULL_TURN          = 5760;
    localparam int PROJ_X_OFFSET      = 120;
    localparam int PROJ_Y_OFFSET      = 160;
    localparam logic signed [32:0] CORDIC_K = 33'sd652032874;

    // register byte addresses
    localparam logic [ADDR_W-1:0] REG_ANGLE_X = 5'd0;
    localparam logic [ADDR_W-1:0] REG_ANGLE_Y = 5'd4;
    localparam logic [ADDR_W-1:0] REG_ANGLE_Z = 5'd8;
    localparam logic [ADDR_W-1:0] REG_SCALE   = 5'd12;
    localparam logic [ADDR_W-1:0] REG_SHIFT_X = 5'd16;
    localparam logic [ADDR_W-1:0] REG_SHIFT_Y = 5'd20;
    localparam logic [ADDR_W-1:0] REG_SHIFT_Z = 5'd24;

    // CORDIC step angles, 1/4096 degree
    function automatic logic signed [20:0] atan_lut(input logic [3:0] i);
        case (i)
            4'd0:    atan_lut = 21'sd184320;
            4'd1:    atan_lut = 21'sd108810;
            4'd2:    atan_lut = 21'sd57492;
            4'd3:    atan_lut = 21'sd29184;
            4'd4:    atan_lut = 21'sd14649;
            4'd5:    atan_lut = 21'sd7331;
            4'd6:    atan_lut = 21'sd3667;
            4'd7:    atan_lut = 21'sd1833;
            4'd8:    atan_lut = 21'sd917;
            4'd9:    atan_lut = 21'sd458;
            4'd10:   atan_lut = 21'sd229;
            4'd11:   atan_lut = 21'sd115;
            4'd12:   atan_lut = 21'sd57;
            4'd13:   atan_lut = 21'sd29;
            default: atan_lut = 21'sd14;
        endcase
    endfunction

    typedef enum logic [3:0] {
        TR_IDLE = 4'b0001,
        TR_LOAD = 4'b0010,
        TR_ITER = 4'b0100,
        TR_DONE = 4'b1000
    } trig_state_t;

endpackage

@@ sv/vrsp_trig.sv @@
// Iterative CORDIC: one axis at a time, one micro-rotation per cycle.
module vrsp_trig #(
    parameter int TRIG_FRAC_BITS = vrsp_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [3*vrsp_pkg::ANGLE_W-1:0]    angles,   // x, y, z from low bits
    output logic                              busy,
    output logic signed [TRIG_FRAC_BITS+1:0]  sin_x,
    output logic signed [TRIG_FRAC_BITS+1:0]  cos_x,
    output logic signed [TRIG_FRAC_BITS+1:0]  sin_y,
    output logic signed [TRIG_FRAC_BITS+1:0]  cos_y,
    output logic signed [TRIG_FRAC_BITS+1:0]  sin_z,
    output logic signed [TRIG_FRAC_BITS+1:0]  cos_z
);
    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int AW = vrsp_pkg::ANGLE_W;

    vrsp_pkg::trig_state_t state_reg, state_next;
    logic [3:0]  iter_reg, iter_next;
    logic [1:0]  axis_reg, axis_next;
    logic        pend_reg, pend_next;
    logic        negc_reg, negc_next;
    logic signed [33:0] x_reg, x_next, y_reg, y_next;
    logic signed [22:0] z_reg, z_next;
    logic signed [TW-1:0] sin_reg [3];
    logic signed [TW-1:0] cos_reg [3];

    logic [AW-1:0]      ang;
    logic signed [14:0] a, t;
    logic               negc;
    logic signed [33:0] dx, dy;
    logic signed [TW-1:0] sin_r, cos_r;

    function automatic logic signed [TW-1:0] to_trig(input logic signed [33:0] v);
        logic signed [34:0] r;
        logic signed [34:0] one;
        begin
            one = 35'sd1 <<< TRIG_FRAC_BITS;
            if (TRIG_FRAC_BITS < 30)
                r = (35'(v) + (35'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
            else
                r = 35'(v);
            if (r > one)
                r = one;
            if (r < -one)
                r = -one;
            to_trig = TW'(r);
        end
    endfunction

    always_comb
    begin
        case (axis_reg)
            2'd0:    ang = angles[AW-1:0];
            2'd1:    ang = angles[2*AW-1:AW];
            default: ang = angles[3*AW-1:2*AW];
        endcase
        a = 15'($unsigned(ang));
        if (a >= 15'(vrsp_pkg::FULL_TURN))
            a = a - 15'(vrsp_pkg::FULL_TURN);
        negc = 1'b0;
        if (a <= 15'(vrsp_pkg::FULL_TURN / 4))
            t = a;
        else if (a <= 15'(3 * vrsp_pkg::FULL_TURN / 4))
        begin
            t    = 15'(vrsp_pkg::FULL_TURN / 2) - a;
            negc = 1'b1;
        end
        else
            t = a - 15'(vrsp_pkg::FULL_TURN);
        dx = y_reg >>> iter_reg;
        dy = x_reg >>> iter_reg;
        sin_r = to_trig(y_reg);
        cos_r = negc_reg ? -to_trig(x_reg) : to_trig(x_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        axis_next  = axis_reg;
        pend_next  = pend_reg | start;
        negc_next  = negc_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        case (state_reg)
            vrsp_pkg::TR_IDLE:
            begin
                if (pend_next)
                begin
                    pend_next  = 1'b0;
                    axis_next  = 2'd0;
                    state_next = vrsp_pkg::TR_LOAD;
                end
            end
            vrsp_pkg::TR_LOAD:
            begin
                x_next     = 34'(vrsp_pkg::CORDIC_K);
                y_next     = '0;
                z_next     = 23'(t) <<< 8;
                negc_next  = negc;
                iter_next  = '0;
                state_next = vrsp_pkg::TR_ITER;
            end
            vrsp_pkg::TR_ITER:
            begin
                if (!z_reg[22])
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - 23'(vrsp_pkg::atan_lut(iter_reg));
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + 23'(vrsp_pkg::atan_lut(iter_reg));
                end
                iter_next = iter_reg + 4'd1;
                if (iter_reg == 4'(vrsp_pkg::CORDIC_ITERS - 1))
                    state_next = vrsp_pkg::TR_DONE;
            end
            vrsp_pkg::TR_DONE:
            begin
                if (axis_reg == 2'd2)
                    state_next = vrsp_pkg::TR_IDLE;
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = vrsp_pkg::TR_LOAD;
                end
            end
            default: state_next = vrsp_pkg::TR_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vrsp_pkg::TR_IDLE;
            pend_reg  <= 1'b1;
            axis_reg  <= '0;
            iter_reg  <= '0;
            negc_reg  <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                sin_reg[k] <= '0;
                cos_reg[k] <= TW'(1) <<< TRIG_FRAC_BITS;
            end
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            axis_reg  <= axis_next;
            iter_reg  <= iter_next;
            negc_reg  <= negc_next;
            if (state_reg == vrsp_pkg::TR_DONE)
            begin
                sin_reg[axis_reg] <= sin_r;
                cos_reg[axis_reg] <= cos_r;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign busy  = (state_reg != vrsp_pkg::TR_IDLE) || pend_reg;
    assign sin_x = sin_reg[0];
    assign cos_x = cos_reg[0];
    assign sin_y = sin_reg[1];
    assign cos_y = cos_reg[1];
    assign sin_z = sin_reg[2];
    assign cos_z = cos_reg[2];

    a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == vrsp_pkg::TR_DONE |-> $past(iter_reg) == 4'(vrsp_pkg::CORDIC_ITERS - 1))
        else $error("cordic finished early");
    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        axis_reg != 2'd3) else $error("bad axis");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy) else $error("start not seen");
endmodule

@@ sv/vrsp_pipe.sv @@
// Rotation datapath. Stages: Z products, Z sums, X products, X sums,
// Y products, Y sums, scale product, clamp+shift, projection.
module vrsp_pipe #(
    parameter int COORD_WIDTH    = vrsp_pkg::COORD_WIDTH_DEF,
    parameter int TRIG_FRAC_BITS = vrsp_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [COORD_WIDTH-1:0]     bx,
    input  logic signed [COORD_WIDTH-1:0]     by,
    input  logic signed [COORD_WIDTH-1:0]     bz,
    input  logic signed [TRIG_FRAC_BITS+1:0]  sx,
    input  logic signed [TRIG_FRAC_BITS+1:0]  cx,
    input  logic signed [TRIG_FRAC_BITS+1:0]  sy,
    input  logic signed [TRIG_FRAC_BITS+1:0]  cy,
    input  logic signed [TRIG_FRAC_BITS+1:0]  sz,
    input  logic signed [TRIG_FRAC_BITS+1:0]  cz,
    input  logic [vrsp_pkg::SCALE_W-1:0]      scale,
    input  logic signed [vrsp_pkg::SHIFT_W-1:0] shx,
    input  logic signed [vrsp_pkg::SHIFT_W-1:0] shy,
    input  logic signed [vrsp_pkg::SHIFT_W-1:0] shz,
    output logic                              out_valid,
    output logic signed [COORD_WIDTH-1:0]     rx,
    output logic signed [COORD_WIDTH-1:0]     ry,
    output logic signed [COORD_WIDTH-1:0]     rz,
    output logic signed [COORD_WIDTH-1:0]     scx,
    output logic signed [COORD_WIDTH-1:0]     scy
);
    localparam int F  = TRIG_FRAC_BITS;
    localparam int TW = F + 2;
    localparam int CW = COORD_WIDTH;
    localparam int PW = CW + TW;          // single product
    localparam int VW = PW + 3;           // stage value width (bounded growth)
    localparam int QW = VW + TW;          // product of value and trig
    localparam int SW = VW + vrsp_pkg::SCALE_W + 1;
    localparam int NS = 9;

    logic [NS-1:0] v_reg;

    // product rounded half away from zero, >> F
    function automatic logic signed [VW-1:0] rnd(input logic signed [QW-1:0] p);
        logic [QW-1:0] m;
        begin
            m = p[QW-1] ? QW'(-p) : QW'(p);
            m = (m + (QW'(1) << (F - 1))) >> F;
            rnd = p[QW-1] ? -VW'(m) : VW'(m);
        end
    endfunction

    // stage 1: Z-axis products
    logic signed [PW-1:0] p_xc_reg, p_ys_reg, p_yc_reg, p_xs_reg;
    logic signed [CW-1:0] z0_reg;
    // stage 2
    logic signed [VW-1:0] x1_reg, y1_reg, z1_reg;
    // stage 3: X-axis products
    logic signed [QW-1:0] q_yc_reg, q_zs_reg, q_ys_reg, q_zc_reg;
    logic signed [VW-1:0] x1d_reg;
    // stage 4
    logic signed [VW-1:0] x2_reg, y2_reg, z2_reg;
    // stage 5: Y-axis products
    logic signed [QW-1:0] q_xc_reg, q_zs2_reg, q_xs_reg, q_zc2_reg;
    logic signed [VW-1:0] y2d_reg;
    // stage 6
    logic signed [VW-1:0] x3_reg, y3_reg, z3_reg;
    // stage 7: scale
    logic signed [SW-1:0] sxp_reg, syp_reg, szp_reg;
    // stage 8
    logic signed [CW-1:0] fx_reg, fy_reg, fz_reg;
    // stage 9
    logic signed [CW-1:0] ox_reg, oy_reg, oz_reg, ocx_reg, ocy_reg;

    function automatic logic signed [CW-1:0] fin(input logic signed [SW-1:0] p,
                                                 input logic signed [vrsp_pkg::SHIFT_W-1:0] sh);
        logic [SW-1:0]        m;
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] hi;
        begin
            hi = (SW'(1) <<< (CW - 1)) - SW'(1);
            m  = p[SW-1] ? SW'(-p) : SW'(p);
            m  = m >> (F + 8);
            s  = p[SW-1] ? -SW'(m) : SW'(m);
            if (s > hi)
                s = hi;
            if (s < -hi - SW'(1))
                s = -hi - SW'(1);
            fin = CW'(s) + CW'(sh);
        end
    endfunction

    // half of z, truncated toward zero
    logic signed [CW-1:0] hz;
    assign hz = CW'((fz_reg + CW'($signed({1'b0, fz_reg[CW-1]}))) >>> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NS-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_xc_reg  <= PW'(bx) * PW'(cz);
            p_ys_reg  <= PW'(by) * PW'(sz);
            p_yc_reg  <= PW'(by) * PW'(cz);
            p_xs_reg  <= PW'(bx) * PW'(sz);
            z0_reg    <= bz;

            x1_reg    <= VW'(p_xc_reg) + VW'(p_ys_reg);
            y1_reg    <= VW'(p_yc_reg) - VW'(p_xs_reg);
            z1_reg    <= VW'(z0_reg) <<< F;

            q_yc_reg  <= QW'(y1_reg) * QW'(cx);
            q_zs_reg  <= QW'(z1_reg) * QW'(sx);
            q_ys_reg  <= QW'(y1_reg) * QW'(sx);
            q_zc_reg  <= QW'(z1_reg) * QW'(cx);
            x1d_reg   <= x1_reg;

            x2_reg    <= x1d_reg;
            y2_reg    <= rnd(q_yc_reg) + rnd(q_zs_reg);
            z2_reg    <= rnd(q_zc_reg) - rnd(q_ys_reg);

            q_xc_reg  <= QW'(x2_reg) * QW'(cy);
            q_zs2_reg <= QW'(z2_reg) * QW'(sy);
            q_xs_reg  <= QW'(x2_reg) * QW'(sy);
            q_zc2_reg <= QW'(z2_reg) * QW'(cy);
            y2d_reg   <= y2_reg;

            x3_reg    <= rnd(q_xc_reg) - rnd(q_zs2_reg);
            y3_reg    <= y2d_reg;
            z3_reg    <= rnd(q_xs_reg) + rnd(q_zc2_reg);

            sxp_reg   <= SW'(x3_reg) * SW'($unsigned(scale));
            syp_reg   <= SW'(y3_reg) * SW'($unsigned(scale));
            szp_reg   <= SW'(z3_reg) * SW'($unsigned(scale));

            fx_reg    <= fin(sxp_reg, shx);
            fy_reg    <= fin(syp_reg, shy);
            fz_reg    <= fin(szp_reg, shz);

            ox_reg    <= fx_reg;
            oy_reg    <= fy_reg;
            oz_reg    <= fz_reg;
            ocx_reg   <= fx_reg + hz + CW'(vrsp_pkg::PROJ_X_OFFSET);
            ocy_reg   <= fy_reg - hz + CW'(vrsp_pkg::PROJ_Y_OFFSET);
        end
    end

    assign out_valid = v_reg[NS-1];
    assign rx  = ox_reg;
    assign ry  = oy_reg;
    assign rz  = oz_reg;
    assign scx = ocx_reg;
    assign scy = ocy_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> v_reg == $past(v_reg)) else $error("pipe moved while stalled");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        en && v_reg[NS-2] |=> out_valid) else $error("item lost in pipe");
    a_proj: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> scx == CW'(rx + CW'((rz + CW'($signed({1'b0, rz[CW-1]}))) >>> 1)
                                 + CW'(vrsp_pkg::PROJ_X_OFFSET)))
        else $error("projection mismatch");
endmodule

@@ sv/vertex_rotate_scale_project_unit.sv @@
// Vertex rotate/scale/project unit. Each item on s_axis is a vertex
// (base_x, base_y, base_z); it is rotated about Z, then X, then Y using cached
// Q1.14 sines/cosines, scaled by Q4.8 scale_factor (truncate toward zero,
// saturate), offset by shift_x/y/z (wrap), and sent on m_axis together with
// the oblique screen projection. Throughput is one item per clock while the
// CORDIC unit is idle and the output is not stalled. The multiplier pipeline
// has three rotation pairs of product and sum stages, a scale product,
// clamp/offset and projection. Writing an angle register restarts the CORDIC
// unit, which holds s_axis_tready low while it recomputes the three axes in
// turn; the same happens after reset. The pipeline stalls as a whole when the
// output is full and not taken.
module vertex_rotate_scale_project_unit #(
    parameter int COORD_WIDTH    = vrsp_pkg::COORD_WIDTH_DEF,
    parameter int TRIG_FRAC_BITS = vrsp_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // base_x, base_y, base_z from bit 0
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // rot_x, rot_y, rot_z, screen_x, screen_y from bit 0
    output logic [((5*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vrsp_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    localparam int CW  = COORD_WIDTH;
    localparam int ODW = ((5*COORD_WIDTH+7)/8)*8;
    localparam int TW  = TRIG_FRAC_BITS + 2;

    logic [vrsp_pkg::ANGLE_W-1:0] angle_x_reg, angle_y_reg, angle_z_reg;
    logic [vrsp_pkg::SCALE_W-1:0] scale_reg;
    logic [vrsp_pkg::SHIFT_W-1:0] shift_x_reg, shift_y_reg, shift_z_reg;
    logic wr, ang_wr, busy, en, pv;
    logic signed [TW-1:0] sx, cx, sy, cy, sz, cz;
    logic signed [CW-1:0] rx, ry, rz, scx, scy;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign ang_wr = wr && (paddr == vrsp_pkg::REG_ANGLE_X || paddr == vrsp_pkg::REG_ANGLE_Y
                           || paddr == vrsp_pkg::REG_ANGLE_Z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_x_reg <= '0;
            angle_y_reg <= '0;
            angle_z_reg <= '0;
            scale_reg   <= 12'd256;
            shift_x_reg <= '0;
            shift_y_reg <= '0;
            shift_z_reg <= '0;
        end
        else if (wr)
        begin
            case (paddr)
                vrsp_pkg::REG_ANGLE_X: angle_x_reg <= pwdata[vrsp_pkg::ANGLE_W-1:0];
                vrsp_pkg::REG_ANGLE_Y: angle_y_reg <= pwdata[vrsp_pkg::ANGLE_W-1:0];
                vrsp_pkg::REG_ANGLE_Z: angle_z_reg <= pwdata[vrsp_pkg::ANGLE_W-1:0];
                vrsp_pkg::REG_SCALE:   scale_reg   <= pwdata[vrsp_pkg::SCALE_W-1:0];
                vrsp_pkg::REG_SHIFT_X: shift_x_reg <= pwdata[vrsp_pkg::SHIFT_W-1:0];
                vrsp_pkg::REG_SHIFT_Y: shift_y_reg <= pwdata[vrsp_pkg::SHIFT_W-1:0];
                vrsp_pkg::REG_SHIFT_Z: shift_z_reg <= pwdata[vrsp_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            vrsp_pkg::REG_ANGLE_X: prdata = 32'(angle_x_reg);
            vrsp_pkg::REG_ANGLE_Y: prdata = 32'(angle_y_reg);
            vrsp_pkg::REG_ANGLE_Z: prdata = 32'(angle_z_reg);
            vrsp_pkg::REG_SCALE:   prdata = 32'(scale_reg);
            vrsp_pkg::REG_SHIFT_X: prdata = 32'(shift_x_reg);
            vrsp_pkg::REG_SHIFT_Y: prdata = 32'(shift_y_reg);
            vrsp_pkg::REG_SHIFT_Z: prdata = 32'(shift_z_reg);
            default:               prdata = '0;
        endcase
    end

    vrsp_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ang_wr),
        .angles ({angle_z_reg, angle_y_reg, angle_x_reg}),
        .busy   (busy),
        .sin_x  (sx), .cos_x (cx),
        .sin_y  (sy), .cos_y (cy),
        .sin_z  (sz), .cos_z (cz)
    );

    // whole pipeline advances unless a finished item sits unread at the end
    assign en            = !pv || m_axis_tready;
    assign s_axis_tready = en && !busy;
    assign m_axis_tvalid = pv;

    vrsp_pipe #(.COORD_WIDTH(COORD_WIDTH), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid && s_axis_tready),
        .bx        (s_axis_tdata[CW-1:0]),
        .by        (s_axis_tdata[2*CW-1:CW]),
        .bz        (s_axis_tdata[3*CW-1:2*CW]),
        .sx (sx), .cx (cx), .sy (sy), .cy (cy), .sz (sz), .cz (cz),
        .scale     (scale_reg),
        .shx       (shift_x_reg),
        .shy       (shift_y_reg),
        .shz       (shift_z_reg),
        .out_valid (pv),
        .rx (rx), .ry (ry), .rz (rz), .scx (scx), .scy (scy)
    );

    assign m_axis_tdata = ODW'({scy, scx, rz, ry, rx});

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_axis_tready) else $error("accepted item during trig update");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_ang_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ang_wr |=> busy) else $error("angle write did not restart trig");
endmodule

@@ dv/vertex_rotate_scale_project_checker.sv @@
module vertex_rotate_scale_project_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [79:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [vrsp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] scr_y;
        logic signed [15:0] scr_x;
        logic signed [15:0] rz;
        logic signed [15:0] ry;
        logic signed [15:0] rx;
    } vertex_out_t;

    logic [vrsp_pkg::ANGLE_W-1:0] angle [3];
    logic [vrsp_pkg::SCALE_W-1:0] scale;
    logic signed [vrsp_pkg::SHIFT_W-1:0] shift [3];
    longint sin_c [3];
    longint cos_c [3];
    vertex_out_t projected_q[$];

    assign pending = projected_q.size();

    function automatic longint q14(longint v);
        longint r;
        r = (v + (longint'(1) <<< 15)) >>> 16;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r;
    endfunction

    // CORDIC in Q2.30, angle folded to +-90 degrees
    task automatic cordic_sincos(input logic [vrsp_pkg::ANGLE_W-1:0] ang, output longint sn,
                                 output longint cs);
        longint a, t, x, y, z, dx, dy;
        bit negc;
        a = ang;
        negc = 0;
        if (a >= vrsp_pkg::FULL_TURN) a -= vrsp_pkg::FULL_TURN;
        if (a <= vrsp_pkg::FULL_TURN / 4) t = a;
        else if (a <= 3 * vrsp_pkg::FULL_TURN / 4)
        begin
            t = vrsp_pkg::FULL_TURN / 2 - a;
            negc = 1;
        end
        else t = a - vrsp_pkg::FULL_TURN;
        x = vrsp_pkg::CORDIC_K;
        y = 0;
        z = t * 256;
        for (int i = 0; i < vrsp_pkg::CORDIC_ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= vrsp_pkg::atan_lut(i[3:0]);
            end
            else
            begin
                x += dx; y -= dy; z += vrsp_pkg::atan_lut(i[3:0]);
            end
        end
        sn = q14(y);
        cs = negc ? -q14(x) : q14(x);
    endtask

    task automatic refresh_trig();
        for (int k = 0; k < 3; k++) cordic_sincos(angle[k], sin_c[k], cos_c[k]);
    endtask

    // product scaled down by 2^14, halves away from zero
    function automatic longint rmul(longint a, longint b);
        longint m;
        bit neg;
        neg = (a < 0) != (b < 0);
        m = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + (longint'(1) <<< 13)) >>> 14;
        return neg ? -m : m;
    endfunction

    function automatic logic signed [15:0] scale_offset(longint v, logic signed [15:0] sh);
        longint m;
        m = ((v < 0 ? -v : v) * longint'(scale)) >>> 22;
        if (v < 0) m = -m;
        if (m > 32767) m = 32767;
        if (m < -32768) m = -32768;
        m = m + sh;
        return m[15:0];
    endfunction

    function automatic vertex_out_t project_vertex(logic [47:0] d);
        longint bx, by, bz, x1, y1, z1, y2, z2, x3, z3, hz;
        vertex_out_t o;
        bx = $signed(d[15:0]);
        by = $signed(d[31:16]);
        bz = $signed(d[47:32]);
        // about Z
        x1 = bx * cos_c[2] + by * sin_c[2];
        y1 = by * cos_c[2] - bx * sin_c[2];
        z1 = bz <<< 14;
        // about X
        y2 = rmul(y1, cos_c[0]) + rmul(z1, sin_c[0]);
        z2 = -rmul(y1, sin_c[0]) + rmul(z1, cos_c[0]);
        // about Y
        x3 = rmul(x1, cos_c[1]) - rmul(z2, sin_c[1]);
        z3 = rmul(x1, sin_c[1]) + rmul(z2, cos_c[1]);
        o.rx = scale_offset(x3, shift[0]);
        o.ry = scale_offset(y2, shift[1]);
        o.rz = scale_offset(z3, shift[2]);
        hz = longint'(o.rz) / 2;
        o.scr_x = 16'(longint'(o.rx) + hz + vrsp_pkg::PROJ_X_OFFSET);
        o.scr_y = 16'(longint'(o.ry) - hz + vrsp_pkg::PROJ_Y_OFFSET);
        return o;
    endfunction

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d got %0d", $time, name,
                     $signed(exp_v), $signed(act_v));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        vertex_out_t exp_o, act_o;
        if (!rst_n)
        begin
            angle = '{default: '0};
            scale = 12'd256;
            shift = '{default: '0};
            projected_q.delete();
            errors = 0;
            refresh_trig();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    vrsp_pkg::REG_ANGLE_X:
                    begin
                        angle[0] = pwdata[vrsp_pkg::ANGLE_W-1:0];
                        refresh_trig();
                    end
                    vrsp_pkg::REG_ANGLE_Y:
                    begin
                        angle[1] = pwdata[vrsp_pkg::ANGLE_W-1:0];
                        refresh_trig();
                    end
                    vrsp_pkg::REG_ANGLE_Z:
                    begin
                        angle[2] = pwdata[vrsp_pkg::ANGLE_W-1:0];
                        refresh_trig();
                    end
                    vrsp_pkg::REG_SCALE:   scale = pwdata[vrsp_pkg::SCALE_W-1:0];
                    vrsp_pkg::REG_SHIFT_X: shift[0] = pwdata[15:0];
                    vrsp_pkg::REG_SHIFT_Y: shift[1] = pwdata[15:0];
                    vrsp_pkg::REG_SHIFT_Z: shift[2] = pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                projected_q.push_back(project_vertex(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                act_o = m_axis_tdata;
                if (projected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected item, expected none got %h", $time,
                             m_axis_tdata);
                end
                else
                begin
                    exp_o = projected_q.pop_front();
                    check_field("rot_x", exp_o.rx, act_o.rx);
                    check_field("rot_y", exp_o.ry, act_o.ry);
                    check_field("rot_z", exp_o.rz, act_o.rz);
                    check_field("screen_x", exp_o.scr_x, act_o.scr_x);
                    check_field("screen_y", exp_o.scr_y, act_o.scr_y);
                end
            end
        end
    end

endmodule

@@ dv/vertex_rotate_scale_project_unit_tb.sv @@
module vertex_rotate_scale_project_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // base_x, base_y, base_z from bit 0
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // rot_x, rot_y, rot_z, screen_x, screen_y from bit 0
    logic [79:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [vrsp_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    bit burst;       // no idling on either side during this phase
    int out_stall;   // cycles the receiver still holds off
    bit took;        // output item taken at the last rising edge

    vertex_rotate_scale_project_unit uut (.*);

    vertex_rotate_scale_project_checker chk (
        .clk, .rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .errors, .pending
    );

    always
    begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    // hard stop, well past the slowest legal run
    initial
    begin
        #3ms;
        $display("vertex_rotate_scale_project_unit_tb: errors");
        $finish;
    end

    // receiver: random stall before each item, none in burst phases
    always @(posedge clk)
        took = m_axis_tvalid && m_axis_tready;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall = 0;
            m_axis_tready <= 1'b1;
        end
        else
        begin
            if (took)
                out_stall = burst ? 0 : $urandom_range(0, 6);
            if (out_stall == 0)
                m_axis_tready <= 1'b1;
            else
            begin
                m_axis_tready <= 1'b0;
                out_stall--;
            end
        end
    end

    // one item on s_axis; leaves tvalid high so back-to-back items need no dip
    task automatic send_vertex(input logic signed [15:0] x, y, z);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [vrsp_pkg::ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drain the pipe, then let the trig unit finish before touching registers
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        while (!s_axis_tready) @(negedge clk);
        @(negedge clk);
    endtask

    task automatic set_all(input logic [12:0] ax, ay, az, input logic [11:0] sc,
                           input logic [15:0] sx, sy, sz);
        // upper data bits of some writes are random: only the register width counts
        write_reg(vrsp_pkg::REG_ANGLE_X, {$urandom_range(0, 1) ? 19'h7ffff : 19'h0, ax});
        write_reg(vrsp_pkg::REG_ANGLE_Y, {19'h0, ay});
        write_reg(vrsp_pkg::REG_ANGLE_Z, {$urandom_range(0, 1) ? 19'h5a5a5 : 19'h0, az});
        write_reg(vrsp_pkg::REG_SCALE,   {20'h0, sc});
        write_reg(vrsp_pkg::REG_SHIFT_X, {16'h0, sx});
        write_reg(vrsp_pkg::REG_SHIFT_Y, {$urandom_range(0, 1) ? 16'hffff : 16'h0, sy});
        write_reg(vrsp_pkg::REG_SHIFT_Z, {16'h0, sz});
        // address past the last register is ignored
        write_reg(vrsp_pkg::REG_SHIFT_Z + 5'd4, $urandom);
        while (!s_axis_tready) @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return $signed(16'($urandom_range(0, 255))) - 16'sd128;
            2:       return $urandom_range(0, 1) ? 16'sd25 : -16'sd25;
            default: return $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
        endcase
    endfunction

    initial
    begin
        logic signed [15:0] ext [4];
        ext = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1};
        rst_n         = 1'b0;
        burst         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // directed, reset settings: cube corners and coordinate extremes
        for (int c = 0; c < 8; c++)
            send_vertex(c[0] ? 16'sd25 : -16'sd25, c[1] ? 16'sd25 : -16'sd25,
                        c[2] ? 16'sd25 : -16'sd25);
        for (int k = 0; k < 12; k++)
            send_vertex(ext[k % 4], ext[(k / 4 + k) % 4], ext[(k + 2 * (k / 4)) % 4]);
        wait_idle();

        for (int ph = 0; ph < 14; ph++)
        begin
            case (ph)
                0: set_all(13'd5759, 13'd5759, 13'd5759, 12'd4095,
                           16'h7fff, 16'h7fff, 16'h7fff);
                1: set_all(13'd8191, 13'd5760, 13'd7000, 12'd0,
                           16'h8000, 16'h8000, 16'h8000);
                2: set_all(13'd1440, 13'd2880, 13'd4320, 12'd256, 16'h0, 16'h0, 16'h0);
                3: set_all(13'd400, 13'd720, 13'd160, 12'd512, 16'd120, 16'hff00, 16'd0);
                default: set_all(13'($urandom), 13'($urandom), 13'($urandom),
                                 12'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom));
            endcase
            burst = (ph % 4 == 3);
            for (int n = 0; n < 100; n++)
                send_vertex(rand_coord(), rand_coord(), rand_coord());
            burst = 1'b0;
            wait_idle();
        end

        repeat (30) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("vertex_rotate_scale_project_unit_tb: clean");
        else
            $display("vertex_rotate_scale_project_unit_tb: errors");
        $finish;
    end

endmodule

@@ files.f @@
sv/vrsp_pkg.sv
sv/vrsp_trig.sv
sv/vrsp_pipe.sv
sv/vertex_rotate_scale_project_unit.sv
dv/vertex_rotate_scale_project_checker.sv
dv/vertex_rotate_scale_project_unit_tb.sv
